// ===== design/bdq_pkg.sv =====
// Package for the bounded deque: request and result types, codes and sequencer states.
`default_nettype none
package bdq_pkg;

    // Widths of the fields on the ports.
    localparam int unsigned OP_W     = 4;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 7;

    // Request codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT  = 4'd0,
        OP_PUSH_BACK   = 4'd1,
        OP_POP_FRONT   = 4'd2,
        OP_POP_BACK    = 4'd3,
        OP_PEEK_FRONT  = 4'd4,
        OP_PEEK_BACK   = 4'd5,
        OP_ITER_RESET  = 4'd6,
        OP_ITER_NEXT   = 4'd7,
        OP_ROTATE      = 4'd8,
        OP_REMOVE      = 4'd9
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_FULL  = 3'd2,
        ST_STALE = 3'd3,
        ST_END   = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD,
        S_READ,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESP
    } t_state;

    // One request item.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] data_in;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [WORD_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  entry_count;
        logic                has_more;
    } t_out;

endpackage
`default_nettype wire

// ===== design/bdq_ram.sv =====
// Entry store of the deque: one write port and one registered read port.
`default_nettype none
module bdq_ram #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 64,
    parameter int unsigned AW         = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Write when asked, and read the addressed entry every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/bdq_slot.sv =====
// Shared address unit: store position of the entry at a given offset from the front.
`default_nettype none
module bdq_slot #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic [AW-1:0] i_front,
    input  wire logic [CW-1:0] i_off,
    output logic      [AW-1:0] o_slot
);

    localparam int unsigned SW = CW + 1;

    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;

    // The sum stays below twice the depth, so one compare and subtract wraps it.
    always_comb begin
        sum = SW'(i_front) + SW'(i_off);
        if (sum >= SW'(DEPTH)) begin
            wrapped = sum - SW'(DEPTH);
        end else begin
            wrapped = sum;
        end
        o_slot = wrapped[AW-1:0];
    end

endmodule
`default_nettype wire

// ===== design/bounded_deque_with_match_remove_unit.sv =====
// Top level of the bounded deque with iterator and remove-first-match.
// Push, iterator reset and errors go from input transfer through S_CMD to the result;
// pop, peek, iterator next and rotate also pass S_READ for the registered store read.
// Remove-match alternates S_SCAN_RD and S_SCAN_CMP per entry up to the match, then
// S_SHIFT_RD and S_SHIFT_WR per later entry. One item is in flight at a time.
// Synchronous active-low reset empties the deque and clears the iterator; no store sweep.
`default_nettype none
module bounded_deque_with_match_remove_unit #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bdq_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bdq_pkg::t_out      o_out_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Sequencer and deque state.
    bdq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_iter, n_iter;
    logic            r_stale, n_stale;
    logic [CW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_waddr, n_waddr;

    // Request and result payload.
    logic [bdq_pkg::OP_W-1:0]     r_op, n_op;
    logic [DATA_WIDTH-1:0]        r_data, n_data;
    logic [DATA_WIDTH-1:0]        r_dout, n_dout;
    bdq_pkg::t_status             r_status, n_status;
    logic                         r_found, n_found;

    // Store and address unit connections.
    logic [CW-1:0]         slot_off;
    logic [AW-1:0]         slot_q;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  is_full;
    logic                  is_empty;
    logic [CW+6:0]         count_ext;

    bdq_slot #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_slot (
        .i_front (r_front),
        .i_off   (slot_off),
        .o_slot  (slot_q)
    );

    bdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_iter  <= '0;
            r_stale <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_iter  <= n_iter;
            r_stale <= n_stale;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_waddr  <= n_waddr;
        r_op     <= n_op;
        r_data   <= n_data;
        r_dout   <= n_dout;
        r_status <= n_status;
        r_found  <= n_found;
    end

    // Sequencer: next state, deque updates and store controls.
    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_iter   = r_iter;
        n_stale  = r_stale;
        n_idx    = r_idx;
        n_waddr  = r_waddr;
        n_op     = r_op;
        n_data   = r_data;
        n_dout   = r_dout;
        n_status = r_status;
        n_found  = r_found;
        slot_off = '0;
        rd_addr  = r_front;
        wr_en    = 1'b0;
        wr_addr  = slot_q;
        wr_data  = r_data;

        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.op;
                    n_data   = i_in_data.data_in[DATA_WIDTH-1:0];
                    n_dout   = '0;
                    n_status = bdq_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_state  = bdq_pkg::S_CMD;
                end
            end

            bdq_pkg::S_CMD: begin
                n_state = bdq_pkg::S_RESP;
                case (r_op) inside
                    bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                        if (is_full) begin
                            n_status = bdq_pkg::ST_FULL;
                        end else begin
                            if (r_op == bdq_pkg::OP_PUSH_FRONT) begin
                                slot_off = CW'(DEPTH - 1);
                                n_front  = slot_q;
                            end else begin
                                slot_off = r_count;
                            end
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                            n_stale = 1'b1;
                        end
                    end
                    bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_PEEK_FRONT: begin
                        if (is_empty) begin
                            n_status = bdq_pkg::ST_EMPTY;
                        end else begin
                            rd_addr = r_front;
                            n_state = bdq_pkg::S_READ;
                            if (r_op == bdq_pkg::OP_POP_FRONT) begin
                                slot_off = CW'(1);
                                n_front  = slot_q;
                                n_count  = r_count - CW'(1);
                                n_stale  = 1'b1;
                            end
                        end
                    end
                    bdq_pkg::OP_POP_BACK, bdq_pkg::OP_PEEK_BACK: begin
                        if (is_empty) begin
                            n_status = bdq_pkg::ST_EMPTY;
                        end else begin
                            slot_off = r_count - CW'(1);
                            rd_addr  = slot_q;
                            n_state  = bdq_pkg::S_READ;
                            if (r_op == bdq_pkg::OP_POP_BACK) begin
                                n_count = r_count - CW'(1);
                                n_stale = 1'b1;
                            end
                        end
                    end
                    bdq_pkg::OP_ITER_RESET: begin
                        n_iter  = '0;
                        n_stale = 1'b0;
                    end
                    bdq_pkg::OP_ITER_NEXT: begin
                        if (r_stale) begin
                            n_status = bdq_pkg::ST_STALE;
                        end else if (r_iter >= r_count) begin
                            n_status = bdq_pkg::ST_END;
                        end else begin
                            slot_off = r_iter;
                            rd_addr  = slot_q;
                            n_iter   = r_iter + CW'(1);
                            n_state  = bdq_pkg::S_READ;
                        end
                    end
                    bdq_pkg::OP_ROTATE: begin
                        if (is_empty) begin
                            n_status = bdq_pkg::ST_EMPTY;
                        end else begin
                            // Front word is read now; the back slot is kept for the write.
                            rd_addr  = r_front;
                            slot_off = r_count;
                            n_waddr  = slot_q;
                            n_state  = bdq_pkg::S_READ;
                        end
                    end
                    bdq_pkg::OP_REMOVE: begin
                        if (is_empty) begin
                            n_status = bdq_pkg::ST_EMPTY;
                        end else begin
                            n_idx   = '0;
                            n_state = bdq_pkg::S_SCAN_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            bdq_pkg::S_READ: begin
                // Read data is back; rotation also copies it to the back and moves the front.
                n_dout  = rd_data;
                n_state = bdq_pkg::S_RESP;
                if (r_op == bdq_pkg::OP_ROTATE) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_waddr;
                    wr_data  = rd_data;
                    slot_off = CW'(1);
                    n_front  = slot_q;
                    n_stale  = 1'b1;
                end
            end

            bdq_pkg::S_SCAN_RD: begin
                slot_off = r_idx;
                rd_addr  = slot_q;
                n_state  = bdq_pkg::S_SCAN_CMP;
            end

            bdq_pkg::S_SCAN_CMP: begin
                if (rd_data == r_data) begin
                    n_found = 1'b1;
                    n_iter  = r_idx;
                    n_stale = 1'b1;
                    if ((r_idx + CW'(1)) == r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = bdq_pkg::S_RESP;
                    end else begin
                        n_state = bdq_pkg::S_SHIFT_RD;
                    end
                end else if ((r_idx + CW'(1)) == r_count) begin
                    // No match: the iterator is left at its end.
                    n_iter  = r_count;
                    n_state = bdq_pkg::S_RESP;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = bdq_pkg::S_SCAN_RD;
                end
            end

            bdq_pkg::S_SHIFT_RD: begin
                slot_off = r_idx + CW'(1);
                rd_addr  = slot_q;
                n_state  = bdq_pkg::S_SHIFT_WR;
            end

            bdq_pkg::S_SHIFT_WR: begin
                // Move the later entry one place toward the front.
                slot_off = r_idx;
                wr_en    = 1'b1;
                wr_data  = rd_data;
                if ((r_idx + CW'(2)) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = bdq_pkg::S_RESP;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = bdq_pkg::S_SHIFT_RD;
                end
            end

            bdq_pkg::S_RESP: begin
                if (i_out_ready) begin
                    n_state = bdq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake and result fields, all taken from registers.
    assign o_in_ready  = (r_state == bdq_pkg::S_IDLE);
    assign o_out_valid = (r_state == bdq_pkg::S_RESP);
    assign count_ext   = (CW + 7)'(r_count);

    always_comb begin
        o_out_data.data_out    = bdq_pkg::WORD_W'(r_dout);
        o_out_data.status      = r_status;
        o_out_data.found       = r_found;
        o_out_data.entry_count = count_ext[bdq_pkg::COUNT_W-1:0];
        o_out_data.has_more    = !r_stale && (r_iter < r_count);
    end

endmodule
`default_nettype wire
